FILE: sv/key_matrix_to_six_key_report_core_defines.svh
// Assertion helpers shared by the checkers of the key report core.
`ifndef KEY_MATRIX_TO_SIX_KEY_REPORT_CORE_DEFINES_SVH
`define KEY_MATRIX_TO_SIX_KEY_REPORT_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KMS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/kms6_pkg.sv
`default_nettype none
package kms6_pkg;

	localparam int ROWS_DEF          = 6;
	localparam int COLUMNS_DEF       = 14;
	localparam int MAPPED_KEYS_DEF   = 52;
	localparam int SCANCODE_BASE_DEF = 4;
	localparam int REPORT_SLOTS_DEF  = 6;

	localparam int ROW_FIELD_W = 3;
	localparam int COL_FIELD_W = 14;
	localparam int CODE_W      = 8;
	localparam int SHOWN_SLOTS = 6;

	typedef struct packed {
		logic [ROW_FIELD_W-1:0] row_index;
		logic [COL_FIELD_W-1:0] column_levels;
	} sample_t;

	typedef struct packed {
		logic              row_changed;
		logic              scan_changed;
		logic [CODE_W-1:0] slot_one;
		logic [CODE_W-1:0] slot_two;
		logic [CODE_W-1:0] slot_three;
		logic [CODE_W-1:0] slot_four;
		logic [CODE_W-1:0] slot_five;
		logic [CODE_W-1:0] slot_six;
	} report_t;

	// One key event toward the slot table.
	typedef struct packed {
		logic              en;
		logic              press;
		logic [CODE_W-1:0] code;
	} slot_upd_t;

endpackage
`default_nettype wire

FILE: sv/kms6_ram.sv
`default_nettype none
module kms6_ram #(
	parameter int WIDTH = 14,
	parameter int DEPTH = 6,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: sv/kms6_slots.sv
`default_nettype none
module kms6_slots
	import kms6_pkg::*;
#(
	parameter int REPORT_SLOTS = REPORT_SLOTS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire slot_upd_t                         upd,
	output logic [SHOWN_SLOTS-1:0][CODE_W-1:0]     shown
);

	localparam int SLOT_W = (REPORT_SLOTS > 1) ? $clog2(REPORT_SLOTS) : 1;

	logic [REPORT_SLOTS-1:0][CODE_W-1:0] slots_q;
	logic [CODE_W-1:0]                   want;
	logic [CODE_W-1:0]                   put;
	logic                                hit;
	logic [SLOT_W-1:0]                   hit_idx;

	// A press fills the first empty slot, a release empties the first match.
	always_comb begin
		want    = upd.press ? '0 : upd.code;
		put     = upd.press ? upd.code : '0;
		hit     = 1'b0;
		hit_idx = '0;
		for (int s = 0; s < REPORT_SLOTS; s++) begin
			if (!hit && slots_q[s] == want) begin
				hit     = 1'b1;
				hit_idx = SLOT_W'(s);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q <= '0;
		end else if (upd.en && hit) begin
			slots_q[hit_idx] <= put;
		end
	end

	for (genvar i = 0; i < SHOWN_SLOTS; i++) begin : g_shown
		if (i < REPORT_SLOTS) begin : g_real
			assign shown[i] = slots_q[i];
		end else begin : g_none
			assign shown[i] = '0;
		end
	end

endmodule
`default_nettype wire

FILE: sv/key_matrix_to_six_key_report_core.sv
// Key matrix to six-key report builder.
// Input channel (sample_valid/sample_ready/sample): one beat per scanned row,
// carrying the row index and the sampled column levels (1 = pressed).
// Output channel (report_valid/report_ready/report): exactly one beat per input
// beat, in order: row-changed flag, scan-changed flag (OR since last row 0)
// and the six report slots.
// Each row is read from a registered row memory, compared with the new
// levels, and every changed column is then applied to the slot table, one
// column per cycle in ascending order; the row is written back at the end.
// An out-of-range row skips the compare and the column walk. One row is in
// flight at a time: the next input beat is taken only once the current
// report has been loaded into the output register.
// Reset: all keys released, all slots empty, scan flag clear; the row memory
// is covered by per-row valid bits, so no clearing pass is needed.
// A stalled report waits in its output register while the next row is taken
// and worked on; that next report is held back until the slot frees.
`default_nettype none
module key_matrix_to_six_key_report_core
	import kms6_pkg::*;
#(
	parameter int ROWS          = ROWS_DEF,
	parameter int COLUMNS       = COLUMNS_DEF,
	parameter int MAPPED_KEYS   = MAPPED_KEYS_DEF,
	parameter int SCANCODE_BASE = SCANCODE_BASE_DEF,
	parameter int REPORT_SLOTS  = REPORT_SLOTS_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    sample_valid,
	output logic         sample_ready,
	input  wire sample_t sample,
	output logic         report_valid,
	input  wire logic    report_ready,
	output report_t      report
);

	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int KEY_W = $clog2(ROWS * COLUMNS + 1);

	typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_SCAN, ST_DONE} state_t;

	state_t                           state_q;
	logic [ROW_W-1:0]                 row_q;
	logic [COLUMNS-1:0]               lev_q;
	logic [COLUMNS-1:0]               diff_q;
	logic [KEY_W-1:0]                 base_q;
	logic                             changed_q;
	logic                             scan_q;
	logic [ROWS-1:0]                  row_valid_q;
	logic                             report_valid_q;
	report_t                          report_q;

	logic                             accept;
	logic                             in_range;
	logic [ROW_W+ROW_FIELD_W-1:0]     row_ext;
	logic [COLUMNS-1:0]               lev_in;
	logic [COLUMNS-1:0]               ram_rdata;
	logic [COLUMNS-1:0]               old_row;
	logic                             row_done;
	logic                             report_load;
	logic [COL_W-1:0]                 col;
	logic [KEY_W-1:0]                 key;
	slot_upd_t                        upd;
	logic [SHOWN_SLOTS-1:0][CODE_W-1:0] shown;

	assign sample_ready = (state_q == ST_IDLE);
	assign accept       = sample_valid && sample_ready;
	assign in_range     = 32'(sample.row_index) < ROWS;
	assign row_ext      = {{ROW_W{1'b0}}, sample.row_index};

	// Columns past the sampled field always read as released.
	for (genvar j = 0; j < COLUMNS; j++) begin : g_lev
		if (j < COL_FIELD_W) begin : g_in
			assign lev_in[j] = sample.column_levels[j];
		end else begin : g_off
			assign lev_in[j] = 1'b0;
		end
	end

	// Pressed bits, one row per entry. A row never written reads as released.
	kms6_ram #(
		.WIDTH(COLUMNS),
		.DEPTH(ROWS)
	) u_rows (
		.clk  (clk),
		.we   (row_done),
		.waddr(row_q),
		.wdata(lev_q),
		.re   (accept),
		.raddr(row_ext[ROW_W-1:0]),
		.rdata(ram_rdata)
	);

	assign old_row  = row_valid_q[row_q] ? ram_rdata : '0;
	assign row_done = (state_q == ST_SCAN) && (diff_q == '0);

	// Load the finished report once the output register is free or being taken.
	assign report_load = (state_q == ST_DONE) && (!report_valid_q || report_ready);

	// Lowest changed column goes first.
	always_comb begin
		col = '0;
		for (int j = COLUMNS - 1; j >= 0; j--) begin
			if (diff_q[j]) begin
				col = COL_W'(j);
			end
		end
	end

	assign key = base_q + KEY_W'(col);

	// Unmapped keys carry code zero, which leaves the slots alone.
	always_comb begin
		upd.en    = (state_q == ST_SCAN) && (diff_q != '0);
		upd.press = lev_q[col];
		upd.code  = (32'(key) < MAPPED_KEYS) ?
			CODE_W'(32'(key) + 32'(SCANCODE_BASE)) : '0;
	end

	kms6_slots #(
		.REPORT_SLOTS(REPORT_SLOTS)
	) u_slots (
		.clk   (clk),
		.arst_n(arst_n),
		.upd   (upd),
		.shown (shown)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			row_q          <= '0;
			lev_q          <= '0;
			diff_q         <= '0;
			base_q         <= '0;
			changed_q      <= 1'b0;
			scan_q         <= 1'b0;
			row_valid_q    <= '0;
			report_valid_q <= 1'b0;
			report_q       <= '0;
		end else begin
			// Raise valid for a new beat, else drop the held beat once taken.
			if (report_load) begin
				report_valid_q <= 1'b1;
			end else if (report_valid_q && report_ready) begin
				report_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						row_q  <= row_ext[ROW_W-1:0];
						lev_q  <= lev_in;
						base_q <= KEY_W'(32'(sample.row_index) * COLUMNS);
						if (in_range) begin
							state_q <= ST_READ;
						end else begin
							// Ignore the sample: no change, hold the scan flag.
							changed_q <= 1'b0;
							state_q   <= ST_DONE;
						end
					end
				end
				ST_READ: begin
					diff_q    <= old_row ^ lev_q;
					changed_q <= |(old_row ^ lev_q);
					state_q   <= ST_SCAN;
				end
				ST_SCAN: begin
					if (row_done) begin
						row_valid_q[row_q] <= 1'b1;
						scan_q  <= (row_q == '0) ? changed_q : (scan_q | changed_q);
						state_q <= ST_DONE;
					end else begin
						// Retire the lowest changed column.
						diff_q <= diff_q & (diff_q - COLUMNS'(1));
					end
				end
				ST_DONE: begin
					if (report_load) begin
						report_q.row_changed  <= changed_q;
						report_q.scan_changed <= scan_q;
						report_q.slot_one     <= shown[0];
						report_q.slot_two     <= shown[1];
						report_q.slot_three   <= shown[2];
						report_q.slot_four    <= shown[3];
						report_q.slot_five    <= shown[4];
						report_q.slot_six     <= shown[5];
						state_q               <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign report_valid = report_valid_q;
	assign report       = report_q;

endmodule
`default_nettype wire

FILE: sv/kms6_checker.sv
`default_nettype none
`include "key_matrix_to_six_key_report_core_defines.svh"
module kms6_checker
	import kms6_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    sample_valid,
	input wire logic    sample_ready,
	input wire sample_t sample,
	input wire logic    report_valid,
	input wire logic    report_ready,
	input wire report_t report
);

	`KMS_ASSERT_NEXT(a_report_hold, clk, arst_n, report_valid && !report_ready, report_valid && $stable(report), "report beat changed while stalled")
	`KMS_ASSERT_NEXT(a_busy_after_take, clk, arst_n, sample_valid && sample_ready, !sample_ready, "took a second row while one is in flight")
	`KMS_ASSERT_NOW(a_scan_covers_row, clk, arst_n, report_valid && report.row_changed, report.scan_changed, "row change missing from scan flag")
	`KMS_ASSERT_NOW(a_slots_distinct, clk, arst_n, report_valid && report.slot_one != '0, report.slot_one != report.slot_two, "same key in two slots")

endmodule

bind key_matrix_to_six_key_report_core kms6_checker u_kms6_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.sample_valid(sample_valid),
	.sample_ready(sample_ready),
	.sample      (sample),
	.report_valid(report_valid),
	.report_ready(report_ready),
	.report      (report)
);
`default_nettype wire

FILE: bench/tb_key_matrix_to_six_key_report_core.sv
`timescale 1ns / 100ps

module tb_key_matrix_to_six_key_report_core;
	import kms6_pkg::*;

	localparam int KEY_TOTAL      = ROWS_DEF * COLUMNS_DEF;
	localparam int RANDOM_ROWS    = 1450;
	localparam int HOLD_AT_REPORT = 500;
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_CYCLES   = 40;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SHOWN_ERRORS   = 10;
	localparam int PRESSED_CAP    = 9;

	localparam logic [COL_FIELD_W-1:0] ALL_UP   = '0;
	localparam logic [COL_FIELD_W-1:0] ALL_DOWN = '1;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    sample_valid = 1'b0;
	logic    sample_ready;
	sample_t sample       = '0;
	logic    report_valid;
	logic    report_ready = 1'b0;
	report_t report;

	key_matrix_to_six_key_report_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.report_valid (report_valid),
		.report_ready (report_ready),
		.report       (report)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Row samples waiting to be sent, and the reports they must produce.
	sample_t pending_samples [$];
	report_t expected_reports [$];

	// Predicted matrix and report state.
	logic              key_down   [KEY_TOTAL];
	logic [CODE_W-1:0] held_slots [REPORT_SLOTS_DEF];
	logic              scan_flag;

	// Column levels the stimulus has last sent per row.
	logic [COL_FIELD_W-1:0] stim_levels [ROWS_DEF];
	int counted_rows;
	int total_samples;

	int samples_taken = 0;
	int reports_taken = 0;
	int mismatches    = 0;
	int send_gap      = 0;
	int recv_gap      = 0;
	int hold_left     = 0;
	logic hold_done   = 1'b0;
	int idle_cycles   = 0;

	// Apply one row sample to the predicted state and build the report it gives.
	// Changed columns are taken in ascending order; a press takes the first empty
	// slot (dropped when none is empty), a release clears the first slot holding
	// its code. Unmapped keys carry code zero, so they leave the slots alone.
	function automatic report_t next_report(input sample_t s);
		report_t           r;
		logic              row_hit;
		logic              level;
		logic              placed;
		int                key;
		logic [CODE_W-1:0] code;
		logic [CODE_W-1:0] match_code;
		logic [CODE_W-1:0] new_code;
		row_hit = 1'b0;
		// Rows past the matrix are ignored: state and accumulator hold.
		if (s.row_index < ROWS_DEF) begin
			for (int col = 0; col < COLUMNS_DEF; col++) begin
				key = int'(s.row_index) * COLUMNS_DEF + col;
				level = s.column_levels[col];
				if (level != key_down[key]) begin
					row_hit = 1'b1;
					key_down[key] = level;
					code = (key < MAPPED_KEYS_DEF) ?
						CODE_W'(key + SCANCODE_BASE_DEF) : '0;
					match_code = level ? '0 : code;
					new_code = level ? code : '0;
					placed = 1'b0;
					for (int sl = 0; sl < REPORT_SLOTS_DEF; sl++) begin
						if (!placed && held_slots[sl] == match_code) begin
							held_slots[sl] = new_code;
							placed = 1'b1;
						end
					end
				end
			end
			// Row zero opens a new scan, so the accumulator restarts there.
			scan_flag = (s.row_index == 0) ? row_hit : (scan_flag | row_hit);
		end
		r.row_changed  = row_hit;
		r.scan_changed = scan_flag;
		r.slot_one     = held_slots[0];
		r.slot_two     = held_slots[1];
		r.slot_three   = held_slots[2];
		r.slot_four    = held_slots[3];
		r.slot_five    = held_slots[4];
		r.slot_six     = held_slots[5];
		return r;
	endfunction

	// Pick the idle cycles before the next beat; every fourth run of 64 beats
	// goes back to back.
	function automatic int draw_gap(input int beat_no);
		if ((beat_no / 64) % 4 == 3)
			return 0;
		return $urandom_range(0, 4);
	endfunction

	// Queue one row sample and track what the matrix now looks like.
	task automatic queue_row(input int row, input logic [COL_FIELD_W-1:0] levels);
		sample_t s;
		s.row_index = ROW_FIELD_W'(row);
		s.column_levels = levels;
		pending_samples.push_back(s);
		if (row < ROWS_DEF) begin
			stim_levels[row] = levels;
			counted_rows++;
		end
	endtask

	// Typing on one row: flip up to two columns, releasing freely but pressing
	// only while few keys are down, so the slot table fills and drains.
	function automatic logic [COL_FIELD_W-1:0] typed_row(input int row);
		logic [COL_FIELD_W-1:0] lv;
		int down;
		int flips;
		int col;
		lv = stim_levels[row];
		down = 0;
		for (int r = 0; r < ROWS_DEF; r++)
			down += $countones(stim_levels[r]);
		flips = $urandom_range(0, 5);
		if (flips > 2)
			flips = 0;
		repeat (flips) begin
			col = $urandom_range(0, COLUMNS_DEF - 1);
			if (lv[col]) begin
				lv[col] = 1'b0;
				down--;
			end else if (down < PRESSED_CAP) begin
				lv[col] = 1'b1;
				down++;
			end
		end
		return lv;
	endfunction

	task automatic check_field(input string name, input int got, input int want);
		if (got != want) begin
			mismatches++;
			if (mismatches <= SHOWN_ERRORS)
				$display("%0t report %0d %s: expected %0d, got %0d",
					$time, reports_taken, name, want, got);
		end
	endtask

	// Sender: take a beat from the pending queue, hold it until accepted, then
	// idle for the drawn number of cycles. Predict at the accepting edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (sample_valid && sample_ready) begin
				expected_reports.push_back(next_report(sample));
				samples_taken <= samples_taken + 1;
			end
			if (!sample_valid || sample_ready) begin
				if (send_gap != 0) begin
					sample_valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (pending_samples.size() != 0) begin
					sample_valid <= 1'b1;
					sample <= pending_samples.pop_front();
					send_gap <= draw_gap(samples_taken);
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: check each report beat against the oldest prediction, then
	// drop ready for the drawn gap. Once, hold ready low for a long stretch
	// while the sender keeps offering, so the block backs up and stalls.
	always @(posedge clk or negedge arst_n) begin : report_side
		int      next_gap;
		report_t want;
		if (!arst_n) begin
			report_ready <= 1'b0;
			recv_gap <= 0;
			hold_left <= 0;
		end else begin
			next_gap = recv_gap;
			if (report_valid && report_ready) begin
				if (expected_reports.size() == 0) begin
					mismatches++;
					if (mismatches <= SHOWN_ERRORS)
						$display("%0t report %0d: expected none, got %h",
							$time, reports_taken, report);
				end else begin
					want = expected_reports.pop_front();
					check_field("row_changed", report.row_changed, want.row_changed);
					check_field("scan_changed", report.scan_changed, want.scan_changed);
					check_field("slot_one", report.slot_one, want.slot_one);
					check_field("slot_two", report.slot_two, want.slot_two);
					check_field("slot_three", report.slot_three, want.slot_three);
					check_field("slot_four", report.slot_four, want.slot_four);
					check_field("slot_five", report.slot_five, want.slot_five);
					check_field("slot_six", report.slot_six, want.slot_six);
				end
				reports_taken <= reports_taken + 1;
				next_gap = draw_gap(reports_taken + 100);
			end
			if (hold_left != 0) begin
				report_ready <= 1'b0;
				hold_left <= hold_left - 1;
				recv_gap <= next_gap;
			end else if (!hold_done && reports_taken == HOLD_AT_REPORT) begin
				report_ready <= 1'b0;
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
				recv_gap <= next_gap;
			end else if (next_gap != 0) begin
				report_ready <= 1'b0;
				recv_gap <= next_gap - 1;
			end else begin
				report_ready <= 1'b1;
				recv_gap <= 0;
			end
		end
	end

	// Watchdog: end the run if no beat moves on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (sample_valid && sample_ready) || (report_valid && report_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int pick;
		int row;
		for (int k = 0; k < KEY_TOTAL; k++)
			key_down[k] = 1'b0;
		for (int sl = 0; sl < REPORT_SLOTS_DEF; sl++)
			held_slots[sl] = '0;
		scan_flag = 1'b0;
		for (int r = 0; r < ROWS_DEF; r++)
			stim_levels[r] = ALL_UP;
		counted_rows = 0;

		// Directed part.
		queue_row(0, ALL_UP);          // no change at all
		queue_row(0, ALL_DOWN);        // fourteen presses: six fit, rest dropped
		queue_row(1, ALL_DOWN);        // table full: every press dropped
		queue_row(7, ALL_DOWN);        // row past the matrix: ignored
		queue_row(6, 14'h1555);        // first row past the matrix
		queue_row(0, ALL_UP);          // releases empty the table
		queue_row(1, ALL_UP);          // releases of codes never placed
		queue_row(3, 14'h3c00);        // unmapped keys: code zero
		queue_row(3, 14'h3e00);        // last mapped key joins
		queue_row(4, ALL_DOWN);        // whole unmapped row
		queue_row(5, 14'h2aaa);
		queue_row(5, 14'h1555);
		queue_row(4, ALL_UP);
		queue_row(5, ALL_UP);
		queue_row(3, ALL_UP);
		queue_row(2, 14'h0007);        // three presses
		queue_row(2, 14'h0005);        // release the middle one
		queue_row(2, 14'h000d);        // next press fills the hole
		queue_row(0, 14'h2001);        // row zero restarts the scan flag
		queue_row(1, ALL_UP);          // quiet row keeps the flag
		queue_row(0, 14'h2001);        // quiet row zero clears it
		queue_row(2, ALL_UP);
		queue_row(0, ALL_UP);

		// Random part: mostly ordered scans with light typing, the rest noise,
		// broken scans and rows past the matrix.
		counted_rows = 0;
		while (counted_rows < RANDOM_ROWS) begin
			pick = $urandom_range(0, 19);
			if (pick < 15) begin
				for (int r = 0; r < ROWS_DEF; r++)
					queue_row(r, typed_row(r));
			end else if (pick < 17) begin
				queue_row($urandom_range(0, 7),
					COL_FIELD_W'($urandom_range(0, (1 << COL_FIELD_W) - 1)));
			end else if (pick < 19) begin
				repeat ($urandom_range(1, 4)) begin
					row = $urandom_range(0, ROWS_DEF - 1);
					queue_row(row, typed_row(row));
				end
			end else begin
				queue_row($urandom_range(ROWS_DEF, 7),
					COL_FIELD_W'($urandom_range(0, (1 << COL_FIELD_W) - 1)));
			end
		end
		total_samples = pending_samples.size();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: wait for every beat to go in and every report to come out,
		// then watch a while longer for stray reports.
		while (samples_taken != total_samples || expected_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (expected_reports.size() != 0)
			$display("%0d reports never arrived", expected_reports.size());
		if (mismatches == 0 && expected_reports.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+sv
sv/kms6_pkg.sv
sv/kms6_ram.sv
sv/kms6_slots.sv
sv/key_matrix_to_six_key_report_core.sv
sv/kms6_checker.sv
bench/tb_key_matrix_to_six_key_report_core.sv
